// ----- rtl/cvralu_pkg.sv -----
// ----------------------------------------------------------------------------
// cvralu_pkg
// Types and codes shared by the complex vector register ALU modules.
// ----------------------------------------------------------------------------
package cvralu_pkg;

    localparam int DATA_W     = 32;
    localparam int SLOT_W     = 5;
    localparam int SLOT_CODES = 32;
    localparam int TOL_W      = 16;

    typedef enum logic [3:0] {
        OP_WRITE    = 4'd0,
        OP_READ     = 4'd1,
        OP_ADD      = 4'd2,
        OP_SUB      = 4'd3,
        OP_CMUL     = 4'd4,
        OP_CDIV     = 4'd5,
        OP_CMP      = 4'd6,
        OP_DOT      = 4'd7,
        OP_SCALE    = 4'd8,
        OP_RSCALAR  = 4'd9
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_DIV_ZERO = 2'd1,
        STAT_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [3:0]               operation;
        logic [SLOT_W-1:0]        first_slot;
        logic [SLOT_W-1:0]        second_slot;
        logic [SLOT_W-1:0]        dest_slot;
        logic signed [DATA_W-1:0] value_re;
        logic signed [DATA_W-1:0] value_im;
        logic                     load_scalar;
        logic signed [DATA_W-1:0] scalar_value;
    } t_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_re;
        logic signed [DATA_W-1:0] result_im;
        logic                     is_equal;
        logic [1:0]               status;
    } t_res;

    typedef enum logic [1:0] {MX_A, MX_B, MX_C, MX_D} t_mx;
    typedef enum logic [1:0] {MY_C, MY_D, MY_S} t_my;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} t_acc;
    typedef enum logic [2:0] {
        SK_NONE, SK_RE, SK_IM, SK_DOT, SK_DEN, SK_DIV_RE, SK_DIV_IM
    } t_sink;

    typedef struct packed {
        logic  clear;
        logic  capture_req;
        logic  rd_second;
        logic  cap_first;
        logic  cap_second;
        logic  exec;
        logic  mul_en;
        t_mx   mul_x;
        t_my   mul_y;
        t_acc  acc_op;
        t_sink sink;
        logic  write_back;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic [3:0] op;
        logic       clear_done;
        logic       div_done;
    } t_stat;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_RD_FIRST, S_RD_SECOND, S_CAPTURE,
        S_EXEC, S_SEQ, S_DIV, S_WB
    } t_state;

endpackage

// ----- rtl/cvralu_ram.sv -----
// ----------------------------------------------------------------------------
// cvralu_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cvralu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/cvralu_ctrl.sv -----
// ----------------------------------------------------------------------------
// cvralu_ctrl
// Controller: sequences slot reads, multiply steps, divides and write-back.
// ----------------------------------------------------------------------------
module cvralu_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  cvralu_pkg::t_stat i_stat,
    output cvralu_pkg::t_cmd  o_cmd
);
    import cvralu_pkg::*;

    t_state     r_state, n_state;
    logic [2:0] r_step, n_step;
    logic       r_div_last, n_div_last;

    logic  st_last;
    logic  st_div;
    logic  st_mul;
    t_mx   st_x;
    t_my   st_y;
    t_acc  st_acc;
    t_sink st_sink;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_step     <= '0;
            r_div_last <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_div_last <= n_div_last;
        end
    end

    // step programme of the multi-step operations
    always_comb begin
        st_last = 1'b0;
        st_div  = 1'b0;
        st_mul  = 1'b0;
        st_x    = MX_A;
        st_y    = MY_C;
        st_acc  = ACC_HOLD;
        st_sink = SK_NONE;
        case (i_stat.op)
            OP_CMUL: begin
                case (r_step)
                    3'd0: begin st_mul = 1'b1; st_x = MX_A; st_y = MY_C; end
                    3'd1: begin
                        st_mul = 1'b1; st_x = MX_B; st_y = MY_D; st_acc = ACC_LOAD;
                    end
                    3'd2: begin
                        st_mul = 1'b1; st_x = MX_A; st_y = MY_D; st_acc = ACC_SUB;
                    end
                    3'd3: begin
                        st_mul = 1'b1; st_x = MX_B; st_y = MY_C;
                        st_acc = ACC_LOAD; st_sink = SK_RE;
                    end
                    3'd4: st_acc = ACC_ADD;
                    default: begin st_sink = SK_IM; st_last = 1'b1; end
                endcase
            end
            OP_DOT: begin
                case (r_step)
                    3'd0: begin st_mul = 1'b1; st_x = MX_A; st_y = MY_C; end
                    3'd1: begin
                        st_mul = 1'b1; st_x = MX_B; st_y = MY_D; st_acc = ACC_LOAD;
                    end
                    3'd2: st_acc = ACC_ADD;
                    default: begin st_sink = SK_DOT; st_last = 1'b1; end
                endcase
            end
            OP_SCALE: begin
                case (r_step)
                    3'd0: begin st_mul = 1'b1; st_x = MX_A; st_y = MY_S; end
                    3'd1: begin
                        st_mul = 1'b1; st_x = MX_B; st_y = MY_S; st_acc = ACC_LOAD;
                    end
                    3'd2: begin st_acc = ACC_LOAD; st_sink = SK_RE; end
                    default: begin st_sink = SK_IM; st_last = 1'b1; end
                endcase
            end
            OP_CDIV: begin
                case (r_step)
                    3'd0: begin st_mul = 1'b1; st_x = MX_C; st_y = MY_C; end
                    3'd1: begin
                        st_mul = 1'b1; st_x = MX_D; st_y = MY_D; st_acc = ACC_LOAD;
                    end
                    3'd2: begin
                        st_mul = 1'b1; st_x = MX_A; st_y = MY_C; st_acc = ACC_ADD;
                    end
                    3'd3: begin
                        st_mul = 1'b1; st_x = MX_B; st_y = MY_D;
                        st_acc = ACC_LOAD; st_sink = SK_DEN;
                    end
                    3'd4: begin
                        st_mul = 1'b1; st_x = MX_B; st_y = MY_C; st_acc = ACC_ADD;
                    end
                    3'd5: begin
                        st_mul = 1'b1; st_x = MX_A; st_y = MY_D;
                        st_acc = ACC_LOAD; st_sink = SK_DIV_RE; st_div = 1'b1;
                    end
                    3'd6: st_acc = ACC_SUB;
                    default: begin
                        st_sink = SK_DIV_IM; st_div = 1'b1; st_last = 1'b1;
                    end
                endcase
            end
            default: st_last = 1'b1;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_div_last = r_div_last;
        o_cmd      = '0;
        busy       = (r_state != S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture_req = 1'b1;
                    n_state           = S_RD_FIRST;
                end
            end
            S_RD_FIRST: begin
                n_state = S_RD_SECOND;
            end
            S_RD_SECOND: begin
                o_cmd.rd_second = 1'b1;
                o_cmd.cap_first = 1'b1;
                n_state         = S_CAPTURE;
            end
            S_CAPTURE: begin
                o_cmd.cap_second = 1'b1;
                n_state          = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_step     = '0;
                case (i_stat.op) inside
                    OP_CMUL, OP_CDIV, OP_DOT, OP_SCALE: n_state = S_SEQ;
                    default:                            n_state = S_WB;
                endcase
            end
            S_SEQ: begin
                o_cmd.mul_en = st_mul;
                o_cmd.mul_x  = st_x;
                o_cmd.mul_y  = st_y;
                o_cmd.acc_op = st_acc;
                o_cmd.sink   = st_sink;
                n_step       = r_step + 3'd1;
                if (st_div) begin
                    n_div_last = st_last;
                    n_state    = S_DIV;
                end else if (st_last) begin
                    n_state = S_WB;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = r_div_last ? S_WB : S_SEQ;
                end
            end
            S_WB: begin
                case (i_stat.op) inside
                    OP_WRITE, OP_ADD, OP_SUB, OP_CMUL, OP_CDIV, OP_SCALE:
                        o_cmd.write_back = 1'b1;
                    default: o_cmd.write_back = 1'b0;
                endcase
                o_cmd.out_load = 1'b1;
                n_state        = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- rtl/cvralu_dp.sv -----
// ----------------------------------------------------------------------------
// cvralu_dp
// Datapath: slot store, shared multiplier and accumulator, restoring divider.
// ----------------------------------------------------------------------------
module cvralu_dp #(
    parameter int SLOT_COUNT = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  cvralu_pkg::t_req                     i_req,
    input  logic                                 i_cfg_we,
    input  logic [cvralu_pkg::TOL_W-1:0]         i_cfg_data,
    input  cvralu_pkg::t_cmd                     i_cmd,
    output cvralu_pkg::t_stat                    o_stat,
    output cvralu_pkg::t_res                     o_res,
    output logic                                 o_valid
);
    import cvralu_pkg::*;

    localparam int AW        = $clog2(SLOT_COUNT);
    localparam int DIV_STEPS = 64 + FRAC_BITS;
    localparam int CW        = $clog2(DIV_STEPS);

    logic [AW-1:0] slot_map [SLOT_CODES];

    genvar g;
    generate
        for (g = 0; g < SLOT_CODES; g++) begin : g_map
            assign slot_map[g] = AW'(g % SLOT_COUNT);
        end
    endgenerate

    t_req                     r_req;
    logic [TOL_W-1:0]         r_tol;
    logic signed [DATA_W-1:0] r_scale;
    logic [AW-1:0]            r_clr;
    logic signed [DATA_W-1:0] r_a, r_b, r_c, r_d;
    logic signed [DATA_W-1:0] r_re, r_im;
    logic                     r_eq, r_ovf, r_dz;
    logic signed [63:0]       r_prod;
    logic signed [64:0]       r_acc;
    logic [63:0]              r_den;
    logic [63:0]              r_nsh;
    logic [63:0]              r_rem;
    logic [33:0]              r_quo;
    logic                     r_big, r_neg, r_dbusy, r_dtgt;
    logic [CW-1:0]            r_cnt;
    t_res                     r_res;
    logic                     r_valid;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [2*DATA_W-1:0]      ram_wdata, ram_rdata;

    logic signed [DATA_W-1:0] mx, my;
    logic [32:0]              acc_sat;
    logic [32:0]              add_re, add_im;
    logic [DATA_W:0]          dif_re, dif_im;
    logic [64:0]              rem_sh;
    logic                     ge;
    logic [63:0]              rem_nx;
    logic [33:0]              q_sh, q_fin;
    logic                     big_nx;
    logic                     div_last;
    logic [DATA_W-1:0]        div_val;
    logic                     div_ovf;
    logic signed [64:0]       acc_mag;

    function automatic logic [32:0] sat_add(input logic [32:0] v);
        if (v[32] == v[31]) begin
            return {1'b0, v[31:0]};
        end
        return {1'b1, v[32] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    function automatic logic [32:0] sat_acc(input logic signed [64:0] v);
        logic signed [64:0] s;
        s = v >>> FRAC_BITS;
        if ((&s[64:31]) || !(|s[64:31])) begin
            return {1'b0, s[31:0]};
        end
        return {1'b1, s[64] ? 32'h8000_0000 : 32'h7FFF_FFFF};
    endfunction

    function automatic logic [DATA_W:0] abs_diff(input logic signed [DATA_W-1:0] x,
                                                  input logic signed [DATA_W-1:0] y);
        if (x >= y) begin
            return {x[DATA_W-1], x} - {y[DATA_W-1], y};
        end
        return {y[DATA_W-1], y} - {x[DATA_W-1], x};
    endfunction

    // slot store, both parts side by side
    assign ram_we    = i_cmd.clear | i_cmd.write_back;
    assign ram_waddr = i_cmd.clear ? r_clr : slot_map[r_req.dest_slot];
    assign ram_wdata = i_cmd.clear ? '0 : {r_re, r_im};
    assign ram_raddr = i_cmd.rd_second ? slot_map[r_req.second_slot]
                                       : slot_map[r_req.first_slot];

    cvralu_ram #(
        .WIDTH (2*DATA_W),
        .DEPTH (SLOT_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        case (i_cmd.mul_x)
            MX_A:    mx = r_a;
            MX_B:    mx = r_b;
            MX_C:    mx = r_c;
            default: mx = r_d;
        endcase
        case (i_cmd.mul_y)
            MY_C:    my = r_c;
            MY_D:    my = r_d;
            default: my = r_scale;
        endcase
    end

    assign acc_sat = sat_acc(r_acc);
    assign add_re  = sat_add((r_req.operation == OP_SUB)
                             ? {r_a[31], r_a} - {r_c[31], r_c}
                             : {r_a[31], r_a} + {r_c[31], r_c});
    assign add_im  = sat_add((r_req.operation == OP_SUB)
                             ? {r_b[31], r_b} - {r_d[31], r_d}
                             : {r_b[31], r_b} + {r_d[31], r_d});
    assign dif_re  = abs_diff(r_a, r_c);
    assign dif_im  = abs_diff(r_b, r_d);
    assign acc_mag = r_acc[64] ? -r_acc : r_acc;

    // restoring divider, one quotient bit per cycle
    assign rem_sh   = {r_rem, r_nsh[63]};
    assign ge       = rem_sh >= {1'b0, r_den};
    assign rem_nx   = ge ? 64'(rem_sh - {1'b0, r_den}) : rem_sh[63:0];
    assign q_sh     = {r_quo[32:0], ge};
    assign big_nx   = r_big | (q_sh > 34'h0_8000_0000);
    assign q_fin    = r_big ? r_quo : q_sh;
    assign div_last = r_dbusy && (r_cnt == CW'(DIV_STEPS-1));

    always_comb begin
        div_ovf = 1'b0;
        if (r_dz) begin
            div_val = '0;
        end else if (big_nx) begin
            div_ovf = 1'b1;
            div_val = r_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (r_neg) begin
            div_val = 32'h0 - q_fin[31:0];
        end else if (q_fin[31]) begin
            div_ovf = 1'b1;
            div_val = 32'h7FFF_FFFF;
        end else begin
            div_val = q_fin[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= '0;
            r_scale <= '0;
            r_clr   <= '0;
            r_dbusy <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tol <= i_cfg_data;
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.exec && r_req.operation == OP_SCALE && r_req.load_scalar) begin
                r_scale <= r_req.scalar_value;
            end
            if (i_cmd.sink == SK_DOT) begin
                r_scale <= acc_sat[31:0];
            end
            if (i_cmd.sink == SK_DIV_RE || i_cmd.sink == SK_DIV_IM) begin
                r_dbusy <= 1'b1;
            end else if (div_last) begin
                r_dbusy <= 1'b0;
            end
            r_valid <= i_cmd.out_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture_req) begin
            r_req <= i_req;
        end
        if (i_cmd.cap_first) begin
            r_a <= ram_rdata[2*DATA_W-1:DATA_W];
            r_b <= ram_rdata[DATA_W-1:0];
        end
        if (i_cmd.cap_second) begin
            r_c <= ram_rdata[2*DATA_W-1:DATA_W];
            r_d <= ram_rdata[DATA_W-1:0];
        end
        if (i_cmd.exec) begin
            r_re  <= '0;
            r_im  <= '0;
            r_eq  <= 1'b0;
            r_ovf <= 1'b0;
            r_dz  <= 1'b0;
            case (r_req.operation)
                OP_WRITE: begin
                    r_re <= r_req.value_re;
                    r_im <= r_req.value_im;
                end
                OP_READ: begin
                    r_re <= r_a;
                    r_im <= r_b;
                end
                OP_ADD, OP_SUB: begin
                    r_re  <= add_re[31:0];
                    r_im  <= add_im[31:0];
                    r_ovf <= add_re[32] | add_im[32];
                end
                OP_CMP: begin
                    r_eq <= (dif_re <= {17'd0, r_tol}) && (dif_im <= {17'd0, r_tol});
                end
                OP_RSCALAR: r_re <= r_scale;
                default: ;
            endcase
        end
        if (i_cmd.mul_en) begin
            r_prod <= mx * my;
        end
        case (i_cmd.acc_op)
            ACC_LOAD: r_acc <= {r_prod[63], r_prod};
            ACC_ADD:  r_acc <= r_acc + {r_prod[63], r_prod};
            ACC_SUB:  r_acc <= r_acc - {r_prod[63], r_prod};
            default: ;
        endcase
        case (i_cmd.sink)
            SK_RE, SK_DOT: begin
                r_re <= acc_sat[31:0];
                if (acc_sat[32]) r_ovf <= 1'b1;
            end
            SK_IM: begin
                r_im <= acc_sat[31:0];
                if (acc_sat[32]) r_ovf <= 1'b1;
            end
            SK_DEN: begin
                r_den <= r_acc[63:0];
                r_dz  <= (r_acc == '0);
            end
            SK_DIV_RE, SK_DIV_IM: begin
                r_neg  <= r_acc[64];
                r_nsh  <= acc_mag[63:0];
                r_rem  <= '0;
                r_quo  <= '0;
                r_big  <= 1'b0;
                r_cnt  <= '0;
                r_dtgt <= (i_cmd.sink == SK_DIV_IM);
            end
            default: ;
        endcase
        if (r_dbusy) begin
            r_nsh <= {r_nsh[62:0], 1'b0};
            r_rem <= rem_nx;
            r_quo <= q_fin;
            r_big <= big_nx;
            r_cnt <= r_cnt + CW'(1);
            if (div_last) begin
                if (r_dtgt) r_im <= div_val;
                else        r_re <= div_val;
                if (div_ovf) r_ovf <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_res.result_re <= r_re;
            r_res.result_im <= r_im;
            r_res.is_equal  <= r_eq;
            r_res.status    <= r_ovf ? STAT_OVERFLOW : (r_dz ? STAT_DIV_ZERO : STAT_OK);
        end
    end

    assign o_stat.op         = r_req.operation;
    assign o_stat.clear_done = (r_clr == AW'(SLOT_COUNT-1));
    assign o_stat.div_done   = div_last;
    assign o_res             = r_res;
    assign o_valid           = r_valid;

endmodule

// ----- rtl/complex_vector_register_alu_top.sv -----
// ----------------------------------------------------------------------------
// complex_vector_register_alu_top
// Complex vector register ALU: slot store of fixed-point pairs and a scalar.
// ----------------------------------------------------------------------------
// after reset a clearing pass over every slot keeps busy high
// one request at a time; o_valid pulses one cycle, receiver cannot stall
// write, read, add, sub, compare, read scalar go straight from execute to write-back
// dot, scale and complex multiply step through the shared 32x32 multiplier
// complex divide also runs the bit-serial divider
// ----------------------------------------------------------------------------
module complex_vector_register_alu_top #(
    parameter int SLOT_COUNT = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  cvralu_pkg::t_req              i_req,
    input  logic                          i_cfg_we,
    input  logic [cvralu_pkg::TOL_W-1:0]  i_cfg_data,
    output cvralu_pkg::t_res              o_res,
    output logic                          o_valid
);
    import cvralu_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    cvralu_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    cvralu_dp #(
        .SLOT_COUNT (SLOT_COUNT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_res      (o_res),
        .o_valid    (o_valid)
    );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the complex vector register ALU. Requests go in by
// the start/busy handshake in random bursts; an in-bench fixed-point model of
// the slot store, scalar and tolerance predicts every result, which is checked
// field by field as the strobe comes. Directed corner requests come first,
// then tolerance phases and two random runs that mix in extreme values and unused op codes.
// ----------------------------------------------------------------------------
module tb;
    import cvralu_pkg::*;

    localparam int FRAC     = 16;
    localparam int NSLOT    = 32;
    localparam int WD_LIMIT = 3000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_req       i_req = '0;
    logic       i_cfg_we = 1'b0;
    logic [TOL_W-1:0] i_cfg_data = '0;
    t_res       o_res;
    logic       o_valid;

    complex_vector_register_alu_top #(.SLOT_COUNT(NSLOT), .FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data), .o_res(o_res), .o_valid(o_valid)
    );

    always #5 i_clk = ~i_clk;

    // model state
    logic signed [31:0] pair_re [NSLOT];
    logic signed [31:0] pair_im [NSLOT];
    logic signed [31:0] scalar_reg;
    logic [15:0]        tol_reg;
    logic               sat_hit;

    t_res   pending_res[$];
    int     errors = 0;
    int     n_req = 0, n_res = 0, n_div = 0, n_ovf = 0, n_eq = 0;
    int     burst_left = 0;
    int     idle_cycles = 0;
    logic   accepted_now;

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) begin
            sat_hit = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648) begin
            sat_hit = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic void split_sum(longint p, longint q, output logic neg,
                                      output logic [63:0] mag);
        logic [63:0] u;
        u = p + q;
        if (u == 64'h8000_0000_0000_0000) begin
            neg = 1'b0;
            mag = u;
        end else if (u[63]) begin
            neg = 1'b1;
            mag = -u;
        end else begin
            neg = 1'b0;
            mag = u;
        end
    endfunction

    function automatic logic [31:0] floor_prod(longint p, longint q);
        logic        neg;
        logic [63:0] mag, m;
        split_sum(p, q, neg, mag);
        m = neg ? (mag + ((64'd1 << FRAC) - 1)) >> FRAC : mag >> FRAC;
        return sat32(neg ? -longint'(m) : longint'(m));
    endfunction

    function automatic logic [31:0] quot_part(longint p, longint q, logic [63:0] den);
        logic        neg, big, bitq;
        logic [63:0] n, r, quo;
        split_sum(p, q, neg, n);
        r = 0;
        quo = 0;
        big = 1'b0;
        for (int k = 0; k < 64 + FRAC; k++) begin
            r = (r << 1) | ((k < 64) ? 64'(n[63-k]) : 64'd0);
            bitq = (r >= den);
            if (bitq) r = r - den;
            if (!big) begin
                quo = (quo << 1) | 64'(bitq);
                if (quo > 64'h8000_0000) big = 1'b1;
            end
        end
        if (big) begin
            sat_hit = 1'b1;
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return sat32(neg ? -longint'(quo) : longint'(quo));
    endfunction

    function automatic t_res alu_predict(t_req r);
        t_res        res;
        longint      a, b, c, d, s, da, db;
        logic [63:0] den;
        logic        wr;
        res = '0;
        sat_hit = 1'b0;
        wr = 1'b0;
        a = pair_re[r.first_slot];
        b = pair_im[r.first_slot];
        c = pair_re[r.second_slot];
        d = pair_im[r.second_slot];
        case (r.operation)
            OP_WRITE: begin
                res.result_re = r.value_re;
                res.result_im = r.value_im;
                wr = 1'b1;
            end
            OP_READ: begin
                res.result_re = pair_re[r.first_slot];
                res.result_im = pair_im[r.first_slot];
            end
            OP_ADD: begin
                res.result_re = sat32(a + c);
                res.result_im = sat32(b + d);
                wr = 1'b1;
            end
            OP_SUB: begin
                res.result_re = sat32(a - c);
                res.result_im = sat32(b - d);
                wr = 1'b1;
            end
            OP_CMUL: begin
                res.result_re = floor_prod(a * c, -(b * d));
                res.result_im = floor_prod(a * d, b * c);
                wr = 1'b1;
            end
            OP_CDIV: begin
                den = 64'(c < 0 ? -c : c) * 64'(c < 0 ? -c : c)
                    + 64'(d < 0 ? -d : d) * 64'(d < 0 ? -d : d);
                if (den == 0) begin
                    res.status = STAT_DIV_ZERO;
                end else begin
                    res.result_re = quot_part(a * c, b * d, den);
                    res.result_im = quot_part(b * c, -(a * d), den);
                end
                wr = 1'b1;
            end
            OP_CMP: begin
                da = a - c;
                db = b - d;
                if (da < 0) da = -da;
                if (db < 0) db = -db;
                res.is_equal = (da <= tol_reg) && (db <= tol_reg);
            end
            OP_DOT: begin
                scalar_reg = floor_prod(a * c, b * d);
                res.result_re = scalar_reg;
            end
            OP_SCALE: begin
                if (r.load_scalar) scalar_reg = r.scalar_value;
                s = scalar_reg;
                res.result_re = floor_prod(a * s, 0);
                res.result_im = floor_prod(b * s, 0);
                wr = 1'b1;
            end
            OP_RSCALAR: res.result_re = scalar_reg;
            default: ;
        endcase
        if (wr) begin
            pair_re[r.dest_slot] = res.result_re;
            pair_im[r.dest_slot] = res.result_im;
        end
        if (sat_hit) res.status = STAT_OVERFLOW;
        return res;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res exp_r;
        if (i_rst_n && o_valid) begin
            n_res++;
            if (pending_res.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result re=%h im=%h",
                                           o_res.result_re, o_res.result_im);
            end else begin
                exp_r = pending_res.pop_front();
                if (o_res.result_re !== exp_r.result_re || o_res.result_im !== exp_r.result_im
                    || o_res.is_equal !== exp_r.is_equal || o_res.status !== exp_r.status) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: exp re=%h im=%h eq=%b st=%0d",
                                  " got re=%h im=%h eq=%b st=%0d"},
                                 exp_r.result_re, exp_r.result_im, exp_r.is_equal,
                                 exp_r.status, o_res.result_re, o_res.result_im,
                                 o_res.is_equal, o_res.status);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        accepted_now = start && !busy && i_rst_n;
        if (accepted_now || o_valid) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WD_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_res.size());
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_req(t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        pending_res.push_back(alu_predict(r));
        n_req++;
        if (r.operation == OP_CDIV) n_div++;
        burst_left--;
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        burst_left = 0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_tolerance(logic [15:0] v);
        drain_requests();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tol_reg = v;
        @(posedge i_clk);
    endtask

    function automatic t_req mk(logic [3:0] op, int s1, int s2, int sd);
        t_req r;
        r = '0;
        r.operation = op;
        r.first_slot = SLOT_W'(s1);
        r.second_slot = SLOT_W'(s2);
        r.dest_slot = SLOT_W'(sd);
        return r;
    endfunction

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            1: return 32'h8000_0000 + $urandom_range(0, 3);
            2, 3: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic write_pair(int sd, logic [31:0] re, logic [31:0] im);
        t_req r;
        r = mk(OP_WRITE, 0, 0, sd);
        r.value_re = re;
        r.value_im = im;
        send_req(r);
    endtask

    task automatic test_corners();
        t_req r;
        write_pair(1, 32'h7FFF_FFFF, 32'h8000_0000);
        write_pair(2, 32'h8000_0000, 32'h7FFF_FFFF);
        write_pair(3, 32'h0001_8000, 32'hFFFE_4000);
        send_req(mk(OP_READ, 1, 0, 0));
        send_req(mk(OP_READ, 31, 0, 0));
        send_req(mk(OP_ADD, 1, 1, 4));
        send_req(mk(OP_SUB, 1, 2, 5));
        send_req(mk(OP_CMUL, 1, 2, 6));
        send_req(mk(OP_CMUL, 3, 3, 7));
        send_req(mk(OP_CDIV, 3, 0, 8));
        send_req(mk(OP_CDIV, 3, 3, 9));
        send_req(mk(OP_CDIV, 1, 3, 10));
        send_req(mk(OP_CMP, 1, 1, 0));
        send_req(mk(OP_CMP, 1, 2, 0));
        send_req(mk(OP_DOT, 3, 3, 0));
        send_req(mk(OP_RSCALAR, 0, 0, 0));
        send_req(mk(OP_SCALE, 3, 0, 11));
        r = mk(OP_SCALE, 1, 0, 12);
        r.load_scalar = 1'b1;
        r.scalar_value = 32'h8000_0000;
        send_req(r);
        send_req(mk(OP_ADD, 3, 3, 3));
        send_req(mk(4'd15, 1, 2, 13));
        send_req(mk(4'd10, 3, 3, 3));
        send_req(mk(OP_READ, 3, 0, 0));
    endtask

    task automatic test_tolerance();
        logic [15:0] tols [3] = '{16'd0, 16'd65535, 16'd200};
        foreach (tols[i]) begin
            set_tolerance(tols[i]);
            for (int k = 0; k < 12; k++) begin
                write_pair(20, 32'h0010_0000, 32'hFFF0_0000);
                write_pair(21, 32'h0010_0000 + $urandom_range(0, 70000) - 35000,
                           32'hFFF0_0000 + $urandom_range(0, 400) - 200);
                send_req(mk(OP_CMP, 20, 21, 0));
            end
        end
    endtask

    task automatic test_random(int count);
        t_req r;
        int   pick;
        for (int i = 0; i < count; i++) begin
            r = '0;
            r.first_slot = SLOT_W'($urandom);
            r.second_slot = SLOT_W'($urandom);
            r.dest_slot = SLOT_W'($urandom);
            r.value_re = rand_value();
            r.value_im = rand_value();
            r.load_scalar = 1'($urandom);
            r.scalar_value = rand_value();
            pick = $urandom_range(0, 99);
            if (pick < 25) r.operation = OP_WRITE;
            else if (pick < 30) r.operation = OP_READ;
            else if (pick < 38) r.operation = OP_ADD;
            else if (pick < 46) r.operation = OP_SUB;
            else if (pick < 56) r.operation = OP_CMUL;
            else if (pick < 66) r.operation = OP_CDIV;
            else if (pick < 76) begin
                // compare against a near copy so equality is actually reached
                r.operation = OP_WRITE;
                r.dest_slot = r.second_slot;
                r.value_re = pair_re[r.first_slot] + $urandom_range(0, 600) - 300;
                r.value_im = pair_im[r.first_slot] + $urandom_range(0, 600) - 300;
                send_req(r);
                r.operation = OP_CMP;
            end
            else if (pick < 82) r.operation = OP_DOT;
            else if (pick < 92) r.operation = OP_SCALE;
            else if (pick < 96) r.operation = OP_RSCALAR;
            else r.operation = 4'($urandom_range(10, 15));
            send_req(r);
            if (i == count / 2) drain_requests();
        end
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            pair_re[i] = '0;
            pair_im[i] = '0;
        end
        scalar_reg = '0;
        tol_reg = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_tolerance();
        set_tolerance(16'd300);
        test_random(720);
        set_tolerance(16'd0);
        test_random(720);
        drain_requests();
        repeat (200) @(posedge i_clk);
        $display("covered %0d requests (%0d divides), %0d results checked", n_req, n_div, n_res);
        $display("tolerance phases 0, 65535, 200, 300 and 0; all op codes including unused");
        if (errors == 0 && pending_res.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_res.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/cvralu_pkg.sv
rtl/cvralu_ram.sv
rtl/cvralu_ctrl.sv
rtl/cvralu_dp.sv
rtl/complex_vector_register_alu_top.sv
test/tb.sv
